// ----- design/mbd_pkg.sv -----
// Shared constants, types and channel arithmetic for the mipmap box downsampler.
`default_nettype none
package mbd_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int LINE_DEPTH   = MAX_WIDTH / 2;
    localparam int IDX_W        = $clog2(LINE_DEPTH);
    localparam int CNT_W        = $clog2(MAX_WIDTH);
    localparam int SIZE_W       = 13;
    localparam int PIX_W        = 32;
    localparam int CH_W         = 8;
    localparam int CH_SUM_W     = 9;
    localparam int NUM_CH       = 4;
    localparam int SUM_W        = NUM_CH * CH_SUM_W;
    localparam int SIZE_RESET   = 256;

    typedef enum logic [0:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic             pair_end;
        logic             even_row;
        logic             last;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    function automatic logic [SUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            s[k*CH_SUM_W +: CH_SUM_W] = {1'b0, a[k*CH_W +: CH_W]} + {1'b0, b[k*CH_W +: CH_W]};
        end
        return s;
    endfunction

    function automatic logic [PIX_W-1:0] box_average(input logic [SUM_W-1:0] top,
                                                     input logic [SUM_W-1:0] bottom);
        logic [PIX_W-1:0]    r;
        logic [CH_SUM_W:0]   t;
        r = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            t = {1'b0, top[k*CH_SUM_W +: CH_SUM_W]} + {1'b0, bottom[k*CH_SUM_W +: CH_SUM_W]};
            r[k*CH_W +: CH_W] = t[CH_SUM_W:2];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/mbd_line_buf.sv -----
// Line buffer holding per-channel pair sums of the last even row.
`default_nettype none
module mbd_line_buf (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic                       rd_en,
    input  wire logic [mbd_pkg::IDX_W-1:0]  idx,
    input  wire logic [mbd_pkg::SUM_W-1:0]  wr_data,
    output logic      [mbd_pkg::SUM_W-1:0]  rd_data
);

    logic [mbd_pkg::SUM_W-1:0] mem [mbd_pkg::LINE_DEPTH];
    logic [mbd_pkg::SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- design/mbd_scan.sv -----
// Size registers and raster position counters with per-pixel control decode.
`default_nettype none
module mbd_scan (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [mbd_pkg::SIZE_W-1:0]  cfg_data,
    input  wire logic                        advance,
    output mbd_pkg::scan_ctl_t               ctl
);

    localparam int SW = mbd_pkg::SIZE_W;
    localparam int CW = mbd_pkg::CNT_W;

    logic [SW-1:0] width_reg, width_next;
    logic [SW-1:0] height_reg, height_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [SW-1:0] w_eff, h_eff, w_even, h_even;
    logic [SW-1:0] col_ext, row_ext, col_inc, row_inc;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            unique case (mbd_pkg::cfg_reg_t'(cfg_index))
                mbd_pkg::REG_SRC_WIDTH:  width_next  = cfg_data;
                mbd_pkg::REG_SRC_HEIGHT: height_next = cfg_data;
                default:                 width_next  = width_reg;
            endcase
        end
    end

    always_comb begin
        if (width_reg < SW'(2)) begin
            w_eff = SW'(2);
        end else if (width_reg > SW'(mbd_pkg::MAX_WIDTH)) begin
            w_eff = SW'(mbd_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg < SW'(2)) begin
            h_eff = SW'(2);
        end else if (height_reg > SW'(mbd_pkg::HEIGHT_LIMIT)) begin
            h_eff = SW'(mbd_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = height_reg;
        end
    end

    assign w_even  = {w_eff[SW-1:1], 1'b0};
    assign h_even  = {h_eff[SW-1:1], 1'b0};
    assign col_ext = SW'(col_reg);
    assign row_ext = SW'(row_reg);
    assign col_inc = col_ext + SW'(1);
    assign row_inc = row_ext + SW'(1);

    assign ctl.pair_end = (col_ext < w_even) && (row_ext < h_even) && col_reg[0];
    assign ctl.even_row = ~row_reg[0];
    assign ctl.last     = (row_inc == h_even) && (col_inc == w_even);
    assign ctl.idx      = col_reg[CW-1:1];

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (col_inc >= w_eff) begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[CW-1:0];
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SW'(mbd_pkg::SIZE_RESET);
            height_reg <= SW'(mbd_pkg::SIZE_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/mipmap_box_downsample.sv -----
// Top level of the 2x2 box-filter mipmap downsampler.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[31:0] src_pixel
//  m_      | out | m_tvalid/m_tready  | m_tdata[31:0] dst_pixel, m_tlast last
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index (0 width, 1 height), cfg_data
//
//  One source pixel per cycle while s_tready is high; after the pixel that completes its
//  2x2 block, a result passes through the line buffer read register and the output register.
//  Reset is synchronous on aresetn low; it restores 256x256 and clears the counters.
//  Backpressure on m_ stalls s_ only once both the result and the pending stage are full.
`default_nettype none
module mipmap_box_downsample (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,   // [31:0] src_pixel
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [31:0]                 m_tdata,   // [31:0] dst_pixel
    output logic                             m_tlast,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [mbd_pkg::SIZE_W-1:0]  cfg_data
);

    mbd_pkg::scan_ctl_t          ctl;
    logic                        accept;
    logic                        wr_en, rd_en;
    logic [mbd_pkg::SUM_W-1:0]   ps;
    logic [mbd_pkg::SUM_W-1:0]   rd_data;
    logic                        out_free, st1_free;

    logic [mbd_pkg::PIX_W-1:0]   held_reg, held_next;
    logic                        st1_valid_reg, st1_valid_next;
    logic [mbd_pkg::SUM_W-1:0]   st1_ps_reg, st1_ps_next;
    logic                        st1_last_reg, st1_last_next;
    logic                        m_valid_reg, m_valid_next;
    logic [mbd_pkg::PIX_W-1:0]   m_data_reg, m_data_next;
    logic                        m_last_reg, m_last_next;

    assign cfg_ready = 1'b1;
    assign out_free  = ~m_valid_reg | m_tready;
    assign st1_free  = ~st1_valid_reg | out_free;
    assign s_tready  = st1_free;
    assign accept    = s_tvalid & st1_free;

    mbd_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .ctl       (ctl)
    );

    assign ps    = mbd_pkg::pair_sum(held_reg, s_tdata);
    assign wr_en = accept & ctl.pair_end & ctl.even_row;
    assign rd_en = accept & ctl.pair_end & ~ctl.even_row;

    mbd_line_buf u_line_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .rd_en   (rd_en),
        .idx     (ctl.idx),
        .wr_data (ps),
        .rd_data (rd_data)
    );

    always_comb begin
        held_next      = held_reg;
        st1_valid_next = st1_valid_reg;
        st1_ps_next    = st1_ps_reg;
        st1_last_next  = st1_last_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        // hold the even-column pixel of the pair
        if (accept && !ctl.pair_end) begin
            held_next = s_tdata;
        end
        if (st1_free) begin
            st1_valid_next = rd_en;
        end
        if (rd_en) begin
            st1_ps_next   = ps;
            st1_last_next = ctl.last;
        end
        if (out_free) begin
            m_valid_next = st1_valid_reg;
            if (st1_valid_reg) begin
                m_data_next = mbd_pkg::box_average(rd_data, st1_ps_reg);
                m_last_next = st1_last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            held_reg      <= held_next;
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        st1_ps_reg   <= st1_ps_next;
        st1_last_reg <= st1_last_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

// ----- design/mbd_checker.sv -----
// Port-level checks of the mipmap downsampler, bound to the top level.
`default_nettype none
module mbd_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [31:0]                 s_tdata,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [31:0]                 m_tdata,
    input wire logic                        m_tlast,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready,
    input wire logic [0:0]                  cfg_index,
    input wire logic [mbd_pkg::SIZE_W-1:0]  cfg_data
);

    logic unused_ok;
    assign unused_ok = ^{s_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item dropped or changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with output register empty");

    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result item without an accepted source item");

endmodule

bind mipmap_box_downsample mbd_checker u_mbd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
`default_nettype wire
